>>> hdl/sha_pkg.sv
package sha_pkg;

  localparam int BlockBytes = 64;
  localparam int LenPos = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic       load_word;
    logic [3:0] load_index;
    logic [31:0] load_data;
    logic       init_hash;
    logic       start_round;
    logic       do_round;
    logic [5:0] round_index;
    logic       fold_hash;
    logic [2:0] read_index;
  } dp_cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [0:63];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef4a3f7,32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] initial_h(input logic [2:0] i);
    logic [31:0] h [0:7];
    h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
          32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    return h[i];
  endfunction

endpackage

>>> hdl/sha_stream_if.sv
interface sha_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/sha_datapath.sv
module sha_datapath (
  input  logic            clk,
  input  sha_pkg::dp_cmd_t cmd,
  output logic [31:0]     hash_word
);
  import sha_pkg::*;

  logic [31:0] w [0:15];
  logic [31:0] h [0:7];
  logic [31:0] a, b, c, d, e, f, g, hh;
  logic [31:0] w_t, s0, s1, w_new, big0, big1, ch, maj, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    w_t = w[0];
    big1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch = (e & f) ^ (~e & g);
    t1 = hh + big1 + ch + round_k(cmd.round_index) + w_t;
    big0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    maj = (a & b) ^ (a & c) ^ (b & c);
    t2 = big0 + maj;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      w[cmd.load_index] <= cmd.load_data;
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= w_new;
    end
    if (cmd.start_round) begin
      {a, b, c, d, e, f, g, hh} <= {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
    end else if (cmd.do_round) begin
      {a, b, c, d} <= {t1 + t2, a, b, c};
      {e, f, g, hh} <= {d + t1, e, f, g};
    end
    if (cmd.init_hash) begin
      for (int i = 0; i < 8; i++) h[i] <= initial_h(3'(i));
    end else if (cmd.fold_hash) begin
      h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c; h[3] <= h[3] + d;
      h[4] <= h[4] + e; h[5] <= h[5] + f; h[6] <= h[6] + g; h[7] <= h[7] + hh;
    end
  end

  assign hash_word = h[cmd.read_index];

endmodule

>>> hdl/sha_controller.sv
module sha_controller (
  input  logic              clk,
  input  logic              rst,
  sha_stream_if.sink        in_ch,
  sha_stream_if.source      out_ch,
  output sha_pkg::dp_cmd_t  cmd,
  input  logic [31:0]       hash_word
);
  import sha_pkg::*;

  typedef enum logic [2:0] {IDLE, START, ROUNDS, FOLD, PAD, EMIT} state_t;

  state_t      state;
  logic [5:0]  fill_count;
  logic [63:0] message_bits;
  logic [31:0] word_acc;
  logic [5:0]  round;
  logic        finishing;
  logic        pad_placed;
  logic        len_block;
  logic [2:0]  emit_index;
  logic        out_valid;
  logic [31:0] out_word;
  in_item_t    item;
  logic        take;
  logic [31:0] pad_word;
  logic [3:0]  pad_index;

  assign item = in_ch.payload;
  assign in_ch.ready = (state == IDLE) && !out_valid;
  assign take = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = '{digest_word: out_word, word_index: emit_index,
                            last_word: (emit_index == 3'd7)};

  always_comb begin
    pad_index = fill_count[5:2];
    if (!pad_placed) begin
      case (fill_count[1:0])
        2'd0: pad_word = {PadByte, 24'd0};
        2'd1: pad_word = {word_acc[7:0], PadByte, 16'd0};
        2'd2: pad_word = {word_acc[15:0], PadByte, 8'd0};
        default: pad_word = {word_acc[23:0], PadByte};
      endcase
    end else if (len_block && pad_index == 4'd14) begin
      pad_word = message_bits[63:32];
    end else if (len_block && pad_index == 4'd15) begin
      pad_word = message_bits[31:0];
    end else begin
      pad_word = 32'd0;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.round_index = round;
    cmd.read_index = emit_index;
    cmd.init_hash = rst;
    case (state)
      IDLE: begin
        if (take && item.byte_valid && fill_count[1:0] == 2'd3) begin
          cmd.load_word = 1'b1;
          cmd.load_index = fill_count[5:2];
          cmd.load_data = {word_acc[23:0], item.data_byte};
        end
      end
      PAD: begin
        cmd.load_word = 1'b1;
        cmd.load_index = pad_index;
        cmd.load_data = pad_word;
      end
      START: cmd.start_round = 1'b1;
      ROUNDS: cmd.do_round = 1'b1;
      FOLD: cmd.fold_hash = 1'b1;
      EMIT: cmd.init_hash = rst || (out_ch.ready && out_valid && emit_index == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      fill_count <= '0;
      message_bits <= '0;
      round <= '0;
      finishing <= 1'b0;
      pad_placed <= 1'b0;
      len_block <= 1'b0;
      emit_index <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (take) begin
            finishing <= item.end_of_message;
            if (item.byte_valid) begin
              word_acc <= {word_acc[23:0], item.data_byte};
              fill_count <= fill_count + 6'd1;
              message_bits <= message_bits + 64'd8;
              if (fill_count == 6'd63) state <= START;
              else if (item.end_of_message) state <= PAD;
            end else if (item.end_of_message) begin
              state <= PAD;
            end
            if (item.end_of_message) begin
              pad_placed <= 1'b0;
              len_block <= 1'b0;
            end
          end
        end
        PAD: begin
          pad_placed <= 1'b1;
          if (!pad_placed) len_block <= (fill_count[5:3] != 3'd7);
          if (pad_index == 4'd15) begin
            fill_count <= '0;
            state <= START;
          end else begin
            fill_count <= {pad_index + 4'd1, 2'd0};
          end
        end
        START: state <= ROUNDS;
        ROUNDS: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= FOLD;
        end
        FOLD: begin
          emit_index <= '0;
          if (!finishing) begin
            state <= IDLE;
          end else if (len_block) begin
            state <= EMIT;
            out_valid <= 1'b1;
          end else begin
            state <= PAD;
            len_block <= pad_placed;
          end
        end
        EMIT: begin
          if (out_ch.ready) begin
            emit_index <= emit_index + 3'd1;
            if (emit_index == 3'd7) begin
              out_valid <= 1'b0;
              state <= IDLE;
              finishing <= 1'b0;
              fill_count <= '0;
              message_bits <= '0;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign out_word = hash_word;

endmodule

>>> hdl/sha256_message_hasher.sv
// Channel | Dir | Payload
// in_ch   | in  | data_byte[8], byte_valid, end_of_message
// out_ch  | out | digest_word[32], word_index[3], last_word
// One byte per cycle while idle; each 64th byte starts the round loop (one round a cycle).
// End of message: one or two padded blocks, each one cycle per word loaded from the pad
// point to word 15 (up to 16) plus the round loop, then eight words.
// Reset rst is synchronous and loads the initial hash values.
// A stall on out_ch holds the current word.
module sha256_message_hasher (
  input logic          clk,
  input logic          rst,
  sha_stream_if.sink   in_ch,
  sha_stream_if.source out_ch
);
  import sha_pkg::*;

  dp_cmd_t     cmd;
  logic [31:0] hash_word;

  sha_controller u_ctrl (.clk, .rst, .in_ch, .out_ch, .cmd, .hash_word);
  sha_datapath   u_dp (.clk, .cmd, .hash_word);

endmodule

>>> hdl/sha_checker.sv
module sha_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic last_word,
  input logic [2:0] word_index
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("valid dropped");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7))) else $error("last mismatch");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && word_index != 3'd7 |=> out_valid)
    else $error("gap in digest");
endmodule

bind sha256_message_hasher sha_checker u_chk (.clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .last_word(out_ch.payload.last_word), .word_index(out_ch.payload.word_index));

>>> bench/sha256_message_hasher_tb.sv
module sha256_message_hasher_tb;
  import sha_pkg::*;

  logic clk = 0;
  logic rst = 1;
  always #1 clk = ~clk;

  sha_stream_if #(.payload_t(in_item_t)) in_ch ();
  sha_stream_if #(.payload_t(out_item_t)) out_ch ();

  sha256_message_hasher u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  logic [7:0] blk_bytes [0:63];
  int unsigned fill;
  logic [63:0] msg_bits;
  logic [31:0] hash_h [0:7];
  out_item_t digest_q [$];

  int errors = 0;
  int words_seen = 0;
  int msgs_sent = 0;
  int items_sent = 0;
  int cycles = 0;
  bit quiet = 0;
  bit sink_stall = 1;

  localparam int CycleLimit = 400000;

  function automatic logic [31:0] rr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] k_of(input int t);
    logic [31:0] kt [0:63];
    kt = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef4a3f7,32'hc67178f2};
    return kt[t];
  endfunction

  task automatic restart_hash();
    hash_h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
               32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    fill = 0;
    msg_bits = '0;
  endtask

  task automatic compress_blk();
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    v = hash_h;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_of(t) + w[t];
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic predict_digest(input in_item_t it);
    int unsigned pos;
    out_item_t o;
    if (it.byte_valid) begin
      blk_bytes[fill] = it.data_byte;
      fill++;
      msg_bits += 64'd8;
      if (fill == BlockBytes) begin
        compress_blk();
        fill = 0;
      end
    end
    if (!it.end_of_message) return;
    pos = fill;
    blk_bytes[pos] = PadByte;
    pos++;
    if (pos > LenPos) begin
      while (pos < BlockBytes) begin
        blk_bytes[pos] = 8'h00;
        pos++;
      end
      compress_blk();
      pos = 0;
    end
    while (pos < LenPos) begin
      blk_bytes[pos] = 8'h00;
      pos++;
    end
    for (int k = 0; k < 8; k++) blk_bytes[LenPos+k] = msg_bits[63-8*k -: 8];
    compress_blk();
    for (int k = 0; k < 8; k++) begin
      o.digest_word = hash_h[k];
      o.word_index = k[2:0];
      o.last_word = (k == 7);
      digest_q.push_back(o);
    end
    msgs_sent++;
    restart_hash();
  endtask

  task automatic send_item(input logic [7:0] d, input logic bv, input logic eom);
    in_item_t it;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    it.data_byte = d;
    it.byte_valid = bv;
    it.end_of_message = eom;
    in_ch.valid = 1'b1;
    in_ch.payload = it;
    do @(posedge clk); while (!in_ch.ready);
    predict_digest(it);
    items_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
    in_ch.payload = in_item_t'(10'($urandom));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      words_seen++;
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h idx %0d", got.digest_word, got.word_index);
      end else begin
        want = digest_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d", want.digest_word,
                     want.word_index, want.last_word, got.digest_word, got.word_index,
                     got.last_word);
        end
      end
    end
  end

  initial begin
    int hold;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && sink_stall && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 15);
        out_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(8'($urandom), 1'b1, (i == len - 1));
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (digest_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_message();
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_byte_extremes();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'haa, 1'b1, 1'b1);
  endtask

  task automatic test_pad_boundaries();
    send_message(55);
    wait_drained();
    send_message(56);
  endtask

  task automatic test_random_messages();
    int len;
    while (items_sent < 135) begin
      case ($urandom_range(0, 9))
        0: send_item(8'($urandom), 1'b0, 1'b0);
        1: send_item(8'($urandom), 1'($urandom), 1'($urandom));
        default: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
          send_message(len);
        end
      endcase
    end
  endtask

  task automatic test_no_idle();
    quiet = 1;
    for (int m = 0; m < 3; m++) send_message($urandom_range(1, 12));
  endtask

  initial begin
    int tail;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    restart_hash();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_message();
    test_byte_extremes();
    test_pad_boundaries();
    test_random_messages();
    test_no_idle();
    wait_drained();
    tail = 0;
    while (tail < 300) begin
      @(negedge clk);
      tail++;
    end
    $display("%0d items sent, %0d messages hashed, %0d digest words checked",
             items_sent, msgs_sent, words_seen);
    $display("covered empty, pad-boundary, multi-block and idle-byte messages");
    if (errors == 0 && digest_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d words left", errors, digest_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
